>>> design/bfm_pkg.sv
// shared types, constants and codes for the bloom filter block
`default_nettype none

package bfm_pkg;

    // default sizes
    localparam int MAX_BITS_DEF    = 1024;
    localparam int MAX_HASHES_DEF  = 16;
    localparam int VALUE_BYTES_DEF = 8;

    // field and port widths
    localparam int OPC_W      = 2;
    localparam int VAL_W      = 64;
    localparam int HC_W       = 5;
    localparam int BIU_W      = 11;
    localparam int CNT_W      = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;
    localparam int S_TDATA_W  = 64;
    localparam int M_TDATA_W  = 16;

    // opcodes carried in the input tuser
    localparam logic [OPC_W-1:0] OP_CLEAR  = 2'd0;
    localparam logic [OPC_W-1:0] OP_INSERT = 2'd1;
    localparam logic [OPC_W-1:0] OP_PROBE  = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HASH_COUNT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BITS_IN_USE = 2'd1;

    // configuration reset values
    localparam logic [HC_W-1:0]  HC_RESET  = 5'd3;
    localparam logic [BIU_W-1:0] BIU_RESET = 11'd1024;

    // murmur2 mixing constants
    localparam logic [31:0] MIX_MUL     = 32'h5bd1e995;
    localparam int          MIX_SHIFT   = 24;
    localparam int          FIN_SHIFT_A = 13;
    localparam int          FIN_SHIFT_B = 15;

    // bit store row layout
    localparam int ROW_W     = 32;
    localparam int ROW_BIT_W = 5;

    // modulo unit: quotient bits retired per cycle
    localparam int MOD_BITS_PER_CYCLE = 8;

    // saturation limit of the reported population
    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    // work kinds after classification
    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_CLEAR,
        KIND_INSERT,
        KIND_PROBE
    } t_kind;

    // one queued job
    typedef struct packed {
        t_kind            kind;
        logic [VAL_W-1:0] value;
    } t_job;

    // hash unit commands
    typedef struct packed {
        logic load;
        logic start;
        logic take;
    } t_hash_ctl;

    // hash unit status
    typedef struct packed {
        logic can_start;
        logic valid;
    } t_hash_sts;

endpackage

`default_nettype wire

>>> design/bfm_front.sv
// front end: configuration registers, opcode classification and job queue
`default_nettype none

module bfm_front #(
    parameter  int MAX_BITS   = bfm_pkg::MAX_BITS_DEF,
    parameter  int MAX_HASHES = bfm_pkg::MAX_HASHES_DEF,
    localparam int SIZE_W     = $clog2(MAX_BITS + 1),
    localparam int RCW        = $clog2(MAX_HASHES + 1)
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // input stream
    input  wire logic                           i_s_tvalid,
    output logic                                o_s_tready,
    input  wire logic [bfm_pkg::S_TDATA_W-1:0]  i_s_tdata,   // item_value
    input  wire logic [bfm_pkg::OPC_W-1:0]      i_s_tuser,   // opcode
    // configuration writes
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [bfm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [bfm_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // back end side
    input  wire logic                           i_hold,
    output logic                                o_job_valid,
    input  wire logic                           i_job_ready,
    output bfm_pkg::t_job                       o_job,
    output logic [SIZE_W-1:0]                   o_size,
    output logic [RCW-1:0]                      o_rounds
);
    import bfm_pkg::*;

    localparam int QDEPTH = 2;

    logic [HC_W-1:0]  r_hash_count;
    logic [BIU_W-1:0] r_bits_in_use;
    logic [31:0]      size32;
    logic [31:0]      rnd32;
    t_kind            kind;
    t_job             r_q [QDEPTH];
    logic             r_wp;
    logic             r_rp;
    logic [1:0]       r_cnt;
    logic             push;
    logic             pop;

    // configuration registers, always ready
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash_count  <= HC_RESET;
            r_bits_in_use <= BIU_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_HASH_COUNT:  r_hash_count  <= i_cfg_data[HC_W-1:0];
                CFG_BITS_IN_USE: r_bits_in_use <= i_cfg_data[BIU_W-1:0];
                default: ;
            endcase
        end
    end

    // effective filter size and round count
    always_comb begin
        if (r_bits_in_use == '0) begin
            size32 = 32'd1;
        end else if (32'(r_bits_in_use) > 32'(MAX_BITS)) begin
            size32 = 32'(MAX_BITS);
        end else begin
            size32 = 32'(r_bits_in_use);
        end
        rnd32 = 32'(r_hash_count);
        if (rnd32 > 32'(MAX_HASHES)) begin
            rnd32 = 32'(MAX_HASHES);
        end
        if (rnd32 > size32) begin
            rnd32 = size32;
        end
    end

    assign o_size   = SIZE_W'(size32);
    assign o_rounds = RCW'(rnd32);

    // opcode classification
    always_comb begin
        unique case (i_s_tuser)
            OP_CLEAR:  kind = KIND_CLEAR;
            OP_INSERT: kind = KIND_INSERT;
            OP_PROBE:  kind = KIND_PROBE;
            default:   kind = KIND_NONE;
        endcase
    end

    // two-entry job queue
    assign o_s_tready  = (r_cnt != 2'(QDEPTH)) && !i_hold;
    assign push        = i_s_tvalid && o_s_tready;
    assign o_job_valid = (r_cnt != 2'd0);
    assign pop         = o_job_valid && i_job_ready;
    assign o_job       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= '{kind: kind, value: i_s_tdata};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

endmodule

`default_nettype wire

>>> design/bfm_hash.sv
// chained murmur2 hash unit with one shared 32x32 multiplier
`default_nettype none

module bfm_hash #(
    parameter int VALUE_BYTES = bfm_pkg::VALUE_BYTES_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire bfm_pkg::t_hash_ctl        i_ctl,
    input  wire logic [bfm_pkg::VAL_W-1:0] i_value,
    output bfm_pkg::t_hash_sts             o_sts,
    output logic [31:0]                    o_hash
);
    import bfm_pkg::*;

    // full four-byte blocks, tail bytes, multiplies per round, key prelude steps
    localparam int          NB        = VALUE_BYTES / 4;
    localparam int          TB        = VALUE_BYTES % 4;
    localparam int          NSTEP     = NB + ((TB != 0) ? 1 : 0) + 1;
    localparam int          PRE       = 2 * NB;
    localparam logic [31:0] LEN       = 32'(VALUE_BYTES);
    localparam logic        KL        = 1'(NB - 1);
    localparam logic [31:0] TAIL_MASK = 32'((64'd1 << (8 * TB)) - 64'd1);

    logic [VAL_W-1:0] r_val;
    logic [31:0]      r_kk [2];
    logic [31:0]      r_acc;
    logic [1:0]       r_step;
    logic             r_pre;
    logic             r_run;
    logic             r_hv;
    logic             r_first;
    logic [31:0]      fin_hash;
    logic [31:0]      seed;
    logic [31:0]      word;
    logic [31:0]      tail;
    logic [31:0]      fin_y;
    logic [31:0]      mul_x;
    logic [31:0]      prod;

    assign fin_hash = r_acc ^ (r_acc >> FIN_SHIFT_B);
    assign seed     = r_first ? 32'd0 : fin_hash;
    assign word     = r_step[1] ? r_val[63:32] : r_val[31:0];
    assign tail     = 32'(r_val >> (NB * 32)) & TAIL_MASK;
    assign fin_y    = (TB != 0) ? r_acc : (r_acc ^ r_kk[KL]);

    // multiplier operand: key mixing in the prelude, then the per-round chain
    always_comb begin
        if (i_ctl.start) begin
            mul_x = seed ^ LEN;
        end else if (r_pre) begin
            mul_x = r_step[0] ? (r_acc ^ (r_acc >> MIX_SHIFT)) : word;
        end else if (r_step < 2'(NB)) begin
            mul_x = r_acc ^ r_kk[0];
        end else if ((TB != 0) && (r_step == 2'(NB))) begin
            mul_x = r_acc ^ r_kk[KL] ^ tail;
        end else begin
            mul_x = fin_y ^ (fin_y >> FIN_SHIFT_A);
        end
    end

    assign prod = mul_x * MIX_MUL;

    // sequencing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pre   <= 1'b0;
            r_run   <= 1'b0;
            r_hv    <= 1'b0;
            r_first <= 1'b0;
            r_step  <= 2'd0;
        end else begin
            if (i_ctl.load) begin
                r_pre   <= 1'b1;
                r_step  <= 2'd0;
                r_first <= 1'b1;
                r_hv    <= 1'b0;
            end else if (r_pre) begin
                r_step <= r_step + 2'd1;
                if (r_step == 2'(PRE - 1)) begin
                    r_pre <= 1'b0;
                end
            end else if (i_ctl.start) begin
                r_run   <= 1'b1;
                r_step  <= 2'd1;
                r_first <= 1'b0;
            end else if (r_run) begin
                r_step <= r_step + 2'd1;
                if (r_step == 2'(NSTEP - 1)) begin
                    r_run <= 1'b0;
                    r_hv  <= 1'b1;
                end
            end else if (i_ctl.take) begin
                r_hv <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_val <= i_value;
        end
        if (r_pre || i_ctl.start || r_run) begin
            r_acc <= prod;
        end
        if (r_pre && r_step[0]) begin
            r_kk[r_step[1]] <= prod;
        end
    end

    assign o_hash          = fin_hash;
    assign o_sts.can_start = !r_pre && !r_run && !r_hv;
    assign o_sts.valid     = r_hv;

endmodule

`default_nettype wire

>>> design/bfm_mod.sv
// iterative 32-bit modulo by the filter size, several quotient bits per cycle
`default_nettype none

module bfm_mod #(
    parameter int SIZE_W = 11
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic [31:0]       i_dividend,
    input  wire logic [SIZE_W-1:0] i_divisor,
    output logic                   o_done,
    output logic [SIZE_W-1:0]      o_rem
);
    import bfm_pkg::*;

    localparam int STEPS = MOD_BITS_PER_CYCLE;
    localparam int ITER  = 32 / STEPS;
    localparam int IT_W  = $clog2(ITER);

    logic              r_busy;
    logic              r_done;
    logic [IT_W-1:0]   r_cnt;
    logic [31:0]       r_q;
    logic [SIZE_W-1:0] r_rem;
    logic [SIZE_W-1:0] r_div;
    logic [SIZE_W-1:0] step_rem;
    logic [31:0]       step_q;
    logic [SIZE_W:0]   trial;
    logic              accept;

    assign o_ready = !r_busy;
    assign accept  = i_valid && o_ready;

    // restoring division steps for one cycle
    always_comb begin
        step_rem = r_rem;
        step_q   = r_q;
        trial    = '0;
        for (int j = 0; j < STEPS; j++) begin
            trial = {step_rem, step_q[31]};
            if (trial >= {1'b0, r_div}) begin
                step_rem = SIZE_W'(trial - {1'b0, r_div});
            end else begin
                step_rem = trial[SIZE_W-1:0];
            end
            step_q = step_q << 1;
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (accept) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + IT_W'(1);
                if (r_cnt == IT_W'(ITER - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_q   <= step_q;
            r_rem <= step_rem;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

`default_nettype wire

>>> design/bfm_back.sv
// back end: job sequencer, bit store, population count and result register
`default_nettype none

module bfm_back #(
    parameter  int MAX_BITS    = bfm_pkg::MAX_BITS_DEF,
    parameter  int MAX_HASHES  = bfm_pkg::MAX_HASHES_DEF,
    parameter  int VALUE_BYTES = bfm_pkg::VALUE_BYTES_DEF,
    localparam int SIZE_W      = $clog2(MAX_BITS + 1),
    localparam int RCW         = $clog2(MAX_HASHES + 1)
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // job queue side
    input  wire logic                          i_job_valid,
    output logic                               o_job_ready,
    input  wire bfm_pkg::t_job                 i_job,
    input  wire logic [SIZE_W-1:0]             i_size,
    input  wire logic [RCW-1:0]                i_rounds,
    output logic                               o_init,
    // result stream
    output logic                               o_m_tvalid,
    input  wire logic                          i_m_tready,
    output logic [bfm_pkg::M_TDATA_W-1:0]      o_m_tdata
);
    import bfm_pkg::*;

    localparam int IW   = $clog2(MAX_BITS);
    localparam int ROWS = (MAX_BITS + ROW_W - 1) / ROW_W;
    localparam int RAW  = (ROWS > 1) ? $clog2(ROWS) : 1;

    // sequencer states
    localparam logic [2:0] ST_INIT  = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_CLEAR = 3'd2;
    localparam logic [2:0] ST_HASH  = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    logic [2:0]            r_state,   n_state;
    t_kind                 r_kind,    n_kind;
    logic [RCW-1:0]        r_issued,  n_issued;
    logic [RCW-1:0]        r_retired, n_retired;
    logic                  r_all,     n_all;
    logic [SIZE_W-1:0]     r_pop,     n_pop;
    logic [RAW-1:0]        r_row,     n_row;
    logic                  r_out_v,   n_out_v;
    logic                  r_out_present;
    logic [CNT_W-1:0]      r_out_cnt;
    logic                  out_load;

    logic [ROW_W-1:0]      mem [ROWS];
    logic [ROW_W-1:0]      r_rdata;
    logic                  r_rd_v;
    logic [RAW-1:0]        r_rd_row;
    logic [ROW_BIT_W-1:0]  r_rd_bit;
    logic                  hit;
    logic                  sweep;
    logic                  last_row;
    logic                  mem_we;
    logic [RAW-1:0]        mem_waddr;
    logic [ROW_W-1:0]      mem_wdata;

    t_hash_ctl             hctl;
    t_hash_sts             hsts;
    logic [31:0]           hash;
    logic                  mod_ready;
    logic                  mod_done;
    logic [SIZE_W-1:0]     mod_rem;
    logic [IW+ROW_BIT_W-1:0] idx_wide;
    logic [RAW-1:0]        idx_row;
    logic [ROW_BIT_W-1:0]  idx_bit;

    // hash and modulo units
    bfm_hash #(
        .VALUE_BYTES (VALUE_BYTES)
    ) u_hash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (hctl),
        .i_value (i_job.value),
        .o_sts   (hsts),
        .o_hash  (hash)
    );

    bfm_mod #(
        .SIZE_W (SIZE_W)
    ) u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (hsts.valid),
        .o_ready    (mod_ready),
        .i_dividend (hash),
        .i_divisor  (i_size),
        .o_done     (mod_done),
        .o_rem      (mod_rem)
    );

    // hash unit commands
    assign hctl.load  = (r_state == ST_IDLE) && i_job_valid && (i_rounds != '0) &&
                        ((i_job.kind == KIND_INSERT) || (i_job.kind == KIND_PROBE));
    assign hctl.start = (r_state == ST_HASH) && hsts.can_start && (r_issued != i_rounds);
    assign hctl.take  = hsts.valid && mod_ready;

    // bit index split into row and bit within row
    assign idx_wide = {{ROW_BIT_W{1'b0}}, mod_rem[IW-1:0]};
    assign idx_row  = idx_wide[RAW+ROW_BIT_W-1:ROW_BIT_W];
    assign idx_bit  = idx_wide[ROW_BIT_W-1:0];

    // store write port: clearing sweep or read-modify-write
    assign sweep     = (r_state == ST_INIT) || (r_state == ST_CLEAR);
    assign last_row  = (r_row == RAW'(ROWS - 1));
    assign hit       = r_rdata[r_rd_bit];
    assign mem_we    = sweep || (r_rd_v && (r_kind == KIND_INSERT) && !hit);
    assign mem_waddr = sweep ? r_row : r_rd_row;
    assign mem_wdata = sweep ? '0 : (r_rdata | (ROW_W'(1) << r_rd_bit));

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mod_done) begin
            r_rdata <= mem[idx_row];
        end
    end

    // read stage tags
    always_ff @(posedge i_clk) begin
        if (mod_done) begin
            r_rd_row <= idx_row;
            r_rd_bit <= idx_bit;
        end
    end

    // sequencer
    always_comb begin
        n_state   = r_state;
        n_kind    = r_kind;
        n_issued  = r_issued;
        n_retired = r_retired;
        n_all     = r_all;
        n_pop     = r_pop;
        n_row     = r_row;
        n_out_v   = r_out_v;
        out_load  = 1'b0;

        if (r_out_v && i_m_tready) begin
            n_out_v = 1'b0;
        end

        // retire one hashed bit
        if (r_rd_v) begin
            n_retired = r_retired + RCW'(1);
            if (!hit) begin
                if (r_kind == KIND_INSERT) begin
                    n_pop = r_pop + SIZE_W'(1);
                end else begin
                    n_all = 1'b0;
                end
            end
        end

        unique case (r_state)
            ST_INIT: begin
                n_row = r_row + RAW'(1);
                if (last_row) begin
                    n_row   = '0;
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_job_valid) begin
                    n_kind    = i_job.kind;
                    n_all     = 1'b1;
                    n_issued  = '0;
                    n_retired = '0;
                    n_row     = '0;
                    case (i_job.kind) inside
                        KIND_CLEAR: n_state = ST_CLEAR;
                        KIND_INSERT, KIND_PROBE: begin
                            n_state = (i_rounds == '0) ? ST_DONE : ST_HASH;
                        end
                        default: n_state = ST_DONE;
                    endcase
                end
            end
            ST_CLEAR: begin
                n_row = r_row + RAW'(1);
                if (last_row) begin
                    n_row   = '0;
                    n_pop   = '0;
                    n_state = ST_DONE;
                end
            end
            ST_HASH: begin
                if (hctl.start) begin
                    n_issued = r_issued + RCW'(1);
                end
                if (r_retired == i_rounds) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_v || i_m_tready) begin
                    out_load = 1'b1;
                    n_out_v  = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_INIT;
            r_issued  <= '0;
            r_retired <= '0;
            r_all     <= 1'b1;
            r_pop     <= '0;
            r_row     <= '0;
            r_out_v   <= 1'b0;
            r_rd_v    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_issued  <= n_issued;
            r_retired <= n_retired;
            r_all     <= n_all;
            r_pop     <= n_pop;
            r_row     <= n_row;
            r_out_v   <= n_out_v;
            r_rd_v    <= mod_done;
        end
    end

    // job kind and result payload
    always_ff @(posedge i_clk) begin
        r_kind <= n_kind;
        if (out_load) begin
            r_out_present <= (r_kind == KIND_PROBE) && r_all;
            r_out_cnt     <= (32'(r_pop) > 32'(CNT_MAX)) ? CNT_MAX : CNT_W'(r_pop);
        end
    end

    assign o_job_ready = (r_state == ST_IDLE);
    assign o_init      = (r_state == ST_INIT);
    assign o_m_tvalid  = r_out_v;
    assign o_m_tdata   = {{(M_TDATA_W - CNT_W - 1){1'b0}}, r_out_cnt, r_out_present};

endmodule

`default_nettype wire

>>> design/bloom_filter_murmur2.sv
// top level of the bloom filter block: front end, job queue and back end
//
// Bloom filter over a MAX_BITS bit store. Each input transfer carries an
// opcode in tuser (clear, insert, probe) and a 64-bit value in tdata; every
// input gives exactly one result transfer with the probe answer in bit 0 and
// the saturated population count in bits 11:1. Insert and probe run
// hash_count chained murmur2 rounds, capped at MAX_HASHES and at the filter
// size, on one shared 32x32 multiplier, each hash reduced modulo the filter
// size by an iterative unit retiring eight quotient bits per cycle; that
// modulo unit sets the pace of the rounds, with key mixing, setup, bit
// access and the result on top. An unused opcode or zero rounds goes
// straight to the result. Clear sweeps the store one 32-bit row per cycle.
// After reset the same sweep runs before the first input is taken;
// configuration writes are taken throughout and must only be issued while no
// item is in flight. A two-entry queue lets inputs be taken while the back end
// works and a result waits to be taken.
`default_nettype none

module bloom_filter_murmur2 #(
    parameter int MAX_BITS    = bfm_pkg::MAX_BITS_DEF,
    parameter int MAX_HASHES  = bfm_pkg::MAX_HASHES_DEF,
    parameter int VALUE_BYTES = bfm_pkg::VALUE_BYTES_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // input stream
    input  wire logic                           i_s_tvalid,
    output logic                                o_s_tready,
    input  wire logic [bfm_pkg::S_TDATA_W-1:0]  i_s_tdata,   // [63:0] item_value
    input  wire logic [bfm_pkg::OPC_W-1:0]      i_s_tuser,   // [1:0] opcode
    // result stream
    output logic                                o_m_tvalid,
    input  wire logic                           i_m_tready,
    output logic [bfm_pkg::M_TDATA_W-1:0]       o_m_tdata,   // [0] maybe_present,
                                                             // [11:1] bits_set
    // configuration writes
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [bfm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [bfm_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import bfm_pkg::*;

    localparam int SIZE_W = $clog2(MAX_BITS + 1);
    localparam int RCW    = $clog2(MAX_HASHES + 1);

    logic              hold;
    logic              job_valid;
    logic              job_ready;
    t_job              job;
    logic [SIZE_W-1:0] size;
    logic [RCW-1:0]    rounds;

    // accept, classify and queue
    bfm_front #(
        .MAX_BITS   (MAX_BITS),
        .MAX_HASHES (MAX_HASHES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_hold      (hold),
        .o_job_valid (job_valid),
        .i_job_ready (job_ready),
        .o_job       (job),
        .o_size      (size),
        .o_rounds    (rounds)
    );

    // hashing, bit store and results
    bfm_back #(
        .MAX_BITS    (MAX_BITS),
        .MAX_HASHES  (MAX_HASHES),
        .VALUE_BYTES (VALUE_BYTES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (job_valid),
        .o_job_ready (job_ready),
        .i_job       (job),
        .i_size      (size),
        .i_rounds    (rounds),
        .o_init      (hold),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata)
    );

endmodule

`default_nettype wire
